FILE: src/fastq_stream_statistics_core_macros.svh
// ----------------------------------------------------------------------------
// fastq_stream_statistics_core_macros.svh
// Assertion macros for the FASTQ statistics core. Defining SYNTH empties them.
// ----------------------------------------------------------------------------
`ifndef FASTQ_STREAM_STATISTICS_CORE_MACROS_SVH
`define FASTQ_STREAM_STATISTICS_CORE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication under reset
`define FQS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fqs assertion failed");

// next-cycle implication under reset
`define FQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fqs assertion failed");

`else

`define FQS_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define FQS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/fqs_pkg.sv
// ----------------------------------------------------------------------------
// fqs_pkg
// Types, codes and constants shared by the FASTQ statistics core.
// ----------------------------------------------------------------------------
package fqs_pkg;

    // input word actions
    typedef enum logic [1:0] {
        ACT_DATA   = 2'd0,
        ACT_EOF    = 2'd1,
        ACT_REPORT = 2'd2
    } action_t;

    // record line phase
    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_SEQUENCE = 2'd1,
        PH_PLUS     = 2'd2,
        PH_QUALITY  = 2'd3
    } phase_t;

    // configuration register indexes
    localparam logic [1:0] REG_QUALITY_OFFSET = 2'd0;
    localparam logic [1:0] REG_LOW_MARK       = 2'd1;
    localparam logic [1:0] REG_HIGH_MARK      = 2'd2;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 9;

    // configuration reset values
    localparam logic [7:0] QUALITY_OFFSET_RST = 8'd33;
    localparam logic [8:0] LOW_MARK_RST       = 9'd20;
    localparam logic [8:0] HIGH_MARK_RST      = 9'd30;

    // stream characters
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_C       = 8'h43;
    localparam logic [7:0] CHAR_G       = 8'h47;
    localparam logic [7:0] CHAR_T       = 8'h54;

    // counter slots
    localparam int CNT_BASE      = 0;
    localparam int CNT_READ      = 1;
    localparam int CNT_A         = 2;
    localparam int CNT_C         = 3;
    localparam int CNT_G         = 4;
    localparam int CNT_T         = 5;
    localparam int CNT_LOW       = 6;
    localparam int CNT_HIGH      = 7;
    localparam int CNT_QUAL      = 8;
    localparam int CNT_SEQ_LINE  = 9;
    localparam int NUM_COUNTERS  = 10;

    localparam int OUT_BITS         = 48;
    localparam int MAX_COUNTER_BITS = 64;

    // report view of a counter, zero-extended to the widest counter first
    function automatic logic [OUT_BITS-1:0] out_view(logic [MAX_COUNTER_BITS-1:0] v);
        return v[OUT_BITS-1:0];
    endfunction

endpackage

FILE: src/fqs_sat_counter.sv
// ----------------------------------------------------------------------------
// fqs_sat_counter
// Saturating up counter: adds one per enabled cycle, holds at all ones.
// ----------------------------------------------------------------------------
`include "fastq_stream_statistics_core_macros.svh"

module fqs_sat_counter #(
    parameter int WIDTH = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             inc,
    output logic [WIDTH-1:0] count
);

    logic [WIDTH-1:0] count_reg;
    logic [WIDTH-1:0] count_next;
    logic             at_max;

    // increment unless already full
    assign at_max = (count_reg == {WIDTH{1'b1}});

    always_comb
    begin
        count_next = count_reg;
        if (inc && !at_max)
        begin
            count_next = count_reg + WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

    // a full counter never wraps
    `FQS_ASSERT_NEXT(a_sat_hold, clk, rst_n, at_max, count_reg == {WIDTH{1'b1}})
    // an idle counter keeps its value
    `FQS_ASSERT_NEXT(a_idle_hold, clk, rst_n, !inc, $stable(count_reg))
    // an enabled counter below full steps by one
    `FQS_ASSERT_NEXT(a_inc_step, clk, rst_n, inc && !at_max, count_reg == $past(count_reg) + WIDTH'(1))

endmodule

FILE: src/fastq_stream_statistics_core.sv
// ----------------------------------------------------------------------------
// fastq_stream_statistics_core
// FASTQ text statistics: base, nucleotide, quality and line totals over a
// byte stream, reported on demand.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | sink      | in_valid / in_stall | action, text_byte
//  out     | source    | out_valid/out_stall | ten 48-bit totals
//  cfg     | sink      | cfg_write           | cfg_index, cfg_data
//
//  One word per cycle while in_stall is low; a word is latched, then applied to
//  the counters in the next cycle; a report goes on to the output register.
//  Reset clears all counters, the line phase, and loads default thresholds.
//  in_stall rises only while a report word waits on a full, stalled output
//  register; data and end-of-file words always drain.
// ----------------------------------------------------------------------------
`include "fastq_stream_statistics_core_macros.svh"

module fastq_stream_statistics_core #(
    parameter int COUNTER_BITS = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          action,
    input  logic [7:0]                          text_byte,
    // report stream
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fqs_pkg::OUT_BITS-1:0]        base_total,
    output logic [fqs_pkg::OUT_BITS-1:0]        read_total,
    output logic [fqs_pkg::OUT_BITS-1:0]        adenine_total,
    output logic [fqs_pkg::OUT_BITS-1:0]        cytosine_total,
    output logic [fqs_pkg::OUT_BITS-1:0]        guanine_total,
    output logic [fqs_pkg::OUT_BITS-1:0]        thymine_total,
    output logic [fqs_pkg::OUT_BITS-1:0]        low_mark_total,
    output logic [fqs_pkg::OUT_BITS-1:0]        high_mark_total,
    output logic [fqs_pkg::OUT_BITS-1:0]        quality_byte_total,
    output logic [fqs_pkg::OUT_BITS-1:0]        sequence_line_total,
    // configuration
    input  logic                                cfg_write,
    input  logic [fqs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [fqs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int NC = fqs_pkg::NUM_COUNTERS;

    // configuration registers
    logic [7:0] quality_offset_reg;
    logic [8:0] low_mark_reg;
    logic [8:0] high_mark_reg;

    // input stage
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [1:0] action_reg;
    logic [7:0] byte_reg;

    // line tracking
    fqs_pkg::phase_t phase_reg;
    fqs_pkg::phase_t phase_next;
    logic            line_open_reg;
    logic            line_open_next;

    // handshake
    logic in_accept;
    logic s1_report;
    logic s1_block;
    logic s1_go;
    logic out_load;
    logic out_valid_reg;
    logic out_valid_next;

    // counters
    logic [NC-1:0]           inc;
    logic [COUNTER_BITS-1:0] cnt [NC];
    logic [fqs_pkg::OUT_BITS-1:0] out_reg [NC];

    // quality score compare
    logic signed [9:0] score;
    logic signed [9:0] low_mark_ext;
    logic signed [9:0] high_mark_ext;
    logic              is_newline;
    logic              end_line;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quality_offset_reg <= fqs_pkg::QUALITY_OFFSET_RST;
            low_mark_reg       <= fqs_pkg::LOW_MARK_RST;
            high_mark_reg      <= fqs_pkg::HIGH_MARK_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fqs_pkg::REG_QUALITY_OFFSET: quality_offset_reg <= cfg_data[7:0];
                fqs_pkg::REG_LOW_MARK:       low_mark_reg       <= cfg_data;
                fqs_pkg::REG_HIGH_MARK:      high_mark_reg      <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // handshake: only a report can wait, on a full stalled output
    assign s1_report = (action_reg == fqs_pkg::ACT_REPORT);
    assign s1_block  = s1_report && out_valid_reg && out_stall;
    assign in_stall  = s1_valid_reg && s1_block;
    assign in_accept = in_valid && !in_stall;
    assign s1_go     = s1_valid_reg && !s1_block;
    assign out_load  = s1_go && s1_report;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // input word payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg <= action;
            byte_reg   <= text_byte;
        end
    end

    // quality score against sign-extended marks
    assign score         = $signed({2'b00, byte_reg}) - $signed({2'b00, quality_offset_reg});
    assign low_mark_ext  = $signed({low_mark_reg[8], low_mark_reg});
    assign high_mark_ext = $signed({high_mark_reg[8], high_mark_reg});
    assign is_newline    = (byte_reg == fqs_pkg::CHAR_NEWLINE);

    // word decode: counter enables and line phase
    always_comb
    begin
        inc            = '0;
        phase_next     = phase_reg;
        line_open_next = line_open_reg;
        end_line       = 1'b0;
        if (s1_go)
        begin
            case (action_reg)
                fqs_pkg::ACT_DATA:
                begin
                    if (is_newline)
                    begin
                        end_line       = 1'b1;
                        phase_next     = fqs_pkg::phase_t'(phase_reg + 2'd1);
                        line_open_next = 1'b0;
                    end
                    else
                    begin
                        line_open_next = 1'b1;
                        if (phase_reg == fqs_pkg::PH_SEQUENCE)
                        begin
                            inc[fqs_pkg::CNT_BASE] = 1'b1;
                            inc[fqs_pkg::CNT_A]    = (byte_reg == fqs_pkg::CHAR_A);
                            inc[fqs_pkg::CNT_C]    = (byte_reg == fqs_pkg::CHAR_C);
                            inc[fqs_pkg::CNT_G]    = (byte_reg == fqs_pkg::CHAR_G);
                            inc[fqs_pkg::CNT_T]    = (byte_reg == fqs_pkg::CHAR_T);
                        end
                        else if (phase_reg == fqs_pkg::PH_QUALITY)
                        begin
                            inc[fqs_pkg::CNT_QUAL] = 1'b1;
                            inc[fqs_pkg::CNT_LOW]  = (score >= low_mark_ext);
                            inc[fqs_pkg::CNT_HIGH] = (score >= high_mark_ext);
                        end
                    end
                end
                fqs_pkg::ACT_EOF:
                begin
                    end_line       = line_open_reg;
                    phase_next     = fqs_pkg::PH_HEADER;
                    line_open_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        // line totals count when a line closes
        inc[fqs_pkg::CNT_SEQ_LINE] = end_line && (phase_reg == fqs_pkg::PH_SEQUENCE);
        inc[fqs_pkg::CNT_READ]     = end_line && (phase_reg == fqs_pkg::PH_QUALITY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= fqs_pkg::PH_HEADER;
            line_open_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            line_open_reg <= line_open_next;
        end
    end

    // saturating counters
    for (genvar i = 0; i < NC; i++)
    begin : g_cnt
        fqs_sat_counter #(
            .WIDTH (COUNTER_BITS)
        ) u_cnt (
            .clk   (clk),
            .rst_n (rst_n),
            .inc   (inc[i]),
            .count (cnt[i])
        );
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // snapshot of all totals for a report word
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int k = 0; k < NC; k++)
            begin
                out_reg[k] <= fqs_pkg::out_view(fqs_pkg::MAX_COUNTER_BITS'(cnt[k]));
            end
        end
    end

    assign out_valid           = out_valid_reg;
    assign base_total          = out_reg[fqs_pkg::CNT_BASE];
    assign read_total          = out_reg[fqs_pkg::CNT_READ];
    assign adenine_total       = out_reg[fqs_pkg::CNT_A];
    assign cytosine_total      = out_reg[fqs_pkg::CNT_C];
    assign guanine_total       = out_reg[fqs_pkg::CNT_G];
    assign thymine_total       = out_reg[fqs_pkg::CNT_T];
    assign low_mark_total      = out_reg[fqs_pkg::CNT_LOW];
    assign high_mark_total     = out_reg[fqs_pkg::CNT_HIGH];
    assign quality_byte_total  = out_reg[fqs_pkg::CNT_QUAL];
    assign sequence_line_total = out_reg[fqs_pkg::CNT_SEQ_LINE];

    // only a held report word can stall the input
    `FQS_ASSERT_NOW(a_stall_report, clk, rst_n, in_stall, s1_valid_reg && s1_report)
    // end of file always returns to the header line with no open line
    `FQS_ASSERT_NEXT(a_eof_reset, clk, rst_n, s1_go && (action_reg == fqs_pkg::ACT_EOF), (phase_reg == fqs_pkg::PH_HEADER) && !line_open_reg)
    // a report word always produces a pending result
    `FQS_ASSERT_NEXT(a_report_out, clk, rst_n, out_load, out_valid_reg)
    // line totals never move outside a line close
    `FQS_ASSERT_NOW(a_line_close, clk, rst_n, inc[fqs_pkg::CNT_SEQ_LINE] || inc[fqs_pkg::CNT_READ], end_line && s1_go)

endmodule
